/* design/dcps_pkg.sv */
`timescale 1ns / 1ps

package dcps_pkg;

    // sizes
    localparam int ADC_BITS     = 12;
    localparam int SETTING_BITS = 10;
    localparam int FRAC_BITS    = 8;
    localparam int TH_BITS      = 24;
    localparam int GAIN_BITS    = 16;
    localparam int MUL_A_BITS   = TH_BITS;
    localparam int MUL_BITS     = MUL_A_BITS + GAIN_BITS;
    localparam int SUM_BITS     = MUL_BITS + 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 22;
    localparam int MARGIN_BITS  = 20;
    localparam int OFFSET_BITS  = 22;
    localparam int STEP_BITS    = 3;

    localparam logic [SETTING_BITS-1:0] SETTING_MAX = '1;
    localparam logic [TH_BITS-1:0]      TH_MAX      = '1;

    // item kinds
    localparam logic [2:0] KIND_SAMPLE = 3'd0;
    localparam logic [2:0] KIND_SHORT  = 3'd1;
    localparam logic [2:0] KIND_MODE   = 3'd2;
    localparam logic [2:0] KIND_PLUS   = 3'd3;
    localparam logic [2:0] KIND_MINUS  = 3'd4;
    localparam logic [2:0] KIND_OK     = 3'd5;

    // fault codes
    localparam logic [2:0] FC_NONE = 3'd0;
    localparam logic [2:0] FC_OVP  = 3'd1;
    localparam logic [2:0] FC_OCP  = 3'd2;
    localparam logic [2:0] FC_UVLO = 3'd3;
    localparam logic [2:0] FC_SCP  = 3'd4;

    // menu modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_UVLO  = 2'd1;
    localparam logic [1:0] MODE_VOUT  = 2'd2;
    localparam logic [1:0] MODE_CURR  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_UVLO_GAIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOUT_GAIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVP_MARG  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OCP_OFFS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OCP_GAIN  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PG_UPPER  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PG_LOWER  = 3'd6;

    // register reset values
    localparam logic [GAIN_BITS-1:0]   UVLO_GAIN_RST = 16'd4015;
    localparam logic [GAIN_BITS-1:0]   VOUT_GAIN_RST = 16'd7942;
    localparam logic [MARGIN_BITS-1:0] OVP_MARG_RST  = 20'd23825;
    localparam logic [OFFSET_BITS-1:0] OCP_OFFS_RST  = 22'd317673;
    localparam logic [GAIN_BITS-1:0]   OCP_GAIN_RST  = 16'd3177;
    localparam logic [GAIN_BITS-1:0]   PG_UPPER_RST  = 16'd62259;
    localparam logic [GAIN_BITS-1:0]   PG_LOWER_RST  = 16'd55706;

    // setting reset values, tenths
    localparam logic [SETTING_BITS-1:0] UV_SET_RST  = SETTING_BITS'(110);
    localparam logic [SETTING_BITS-1:0] OUT_SET_RST = SETTING_BITS'(33);
    localparam logic [SETTING_BITS-1:0] CUR_SET_RST = SETTING_BITS'(100);

    // threshold recompute steps
    localparam logic [STEP_BITS-1:0] CALC_TARGET  = 3'd0;
    localparam logic [STEP_BITS-1:0] CALC_UNDER   = 3'd1;
    localparam logic [STEP_BITS-1:0] CALC_OVER    = 3'd2;
    localparam logic [STEP_BITS-1:0] CALC_CURR    = 3'd3;
    localparam logic [STEP_BITS-1:0] CALC_GOOD_HI = 3'd4;
    localparam logic [STEP_BITS-1:0] CALC_GOOD_LO = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic [2:0]          kind;
        logic [ADC_BITS-1:0] uvlo_sample;
        logic [ADC_BITS-1:0] vfb_sample;
        logic [ADC_BITS-1:0] csense_sample;
    } t_in_item;

    typedef struct packed {
        logic                    power_switch_on;
        logic                    converter_shutdown;
        logic                    pwm_running;
        logic                    output_ok;
        logic [2:0]              warning_code;
        logic [1:0]              menu_mode;
        logic [SETTING_BITS-1:0] edit_value;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_DAT_BITS-1:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic in_ready;
        logic cfg_ready;
        logic exec_fire;
        logic calc_en;
    } t_ctrl;

    // sample code widened to a q.8 threshold
    function automatic logic [TH_BITS-1:0] to_q8(input logic [ADC_BITS-1:0] code);
        logic [TH_BITS-1:0] wide;
        wide  = TH_BITS'(code);
        to_q8 = wide << FRAC_BITS;
    endfunction

endpackage

/* design/dcps_item_if.sv */
`timescale 1ns / 1ps

interface dcps_item_if;
    logic                valid;
    logic                ready;
    dcps_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/dcps_result_if.sv */
`timescale 1ns / 1ps

interface dcps_result_if;
    logic                valid;
    logic                ready;
    dcps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/dcps_cfg_if.sv */
`timescale 1ns / 1ps

interface dcps_cfg_if;
    logic                valid;
    logic                ready;
    dcps_pkg::t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/dc_dc_protection_supervisor_top.sv */
`timescale 1ns / 1ps

// Protection supervisor for a dc/dc converter with a three-button settings menu.
// Each input word (ADC sample, short-circuit event, or mode/plus/minus/OK press)
// gives exactly one result word holding the drive lines, power-good, warning
// code, menu mode and edit value after the event. A word is registered when taken
// and decided once the output register can take its result; the result sits in an
// output register, so the next word is taken while a result waits. After reset,
// after any configuration write and after an OK that applies an edited setting,
// one shared 24x16 multiplier with a saturating adder recomputes the five
// thresholds, during which no input word is taken. Configuration writes are
// taken only while the block is idle.
module dc_dc_protection_supervisor_top import dcps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dcps_item_if.sink     i_in,
    dcps_result_if.source o_out,
    dcps_cfg_if.sink      i_cfg
);

    t_state r_state, n_state;
    t_ctrl  ctrl;
    logic   [STEP_BITS-1:0] r_step;

    // configuration registers
    logic [GAIN_BITS-1:0]   r_uvlo_gain, r_vout_gain, r_ocp_gain;
    logic [GAIN_BITS-1:0]   r_pg_upper, r_pg_lower;
    logic [MARGIN_BITS-1:0] r_ovp_margin;
    logic [OFFSET_BITS-1:0] r_ocp_offset;

    // supervisor state
    logic [2:0]              r_fault, n_fault;
    logic [1:0]              r_mode, n_mode;
    logic [SETTING_BITS-1:0] r_edit, n_edit;
    logic [SETTING_BITS-1:0] r_uv_set, n_uv_set;
    logic [SETTING_BITS-1:0] r_out_set, n_out_set;
    logic [SETTING_BITS-1:0] r_cur_set, n_cur_set;
    logic                    r_good, n_good;
    logic                    r_sw_on, n_sw_on;
    logic                    r_shdn, n_shdn;
    logic                    r_pwm, n_pwm;
    logic                    n_recalc;

    // thresholds, q.8
    logic [TH_BITS-1:0] r_target, r_uv_th, r_ov_th, r_oc_th, r_pgu_th, r_pgl_th;

    // shared arithmetic
    logic [MUL_A_BITS-1:0] mul_a;
    logic [GAIN_BITS-1:0]  mul_b;
    logic [MUL_BITS-1:0]   r_prod;
    logic [MUL_BITS-1:0]   add_a;
    logic [OFFSET_BITS-1:0] add_b;
    logic [SUM_BITS-1:0]   sum;
    logic [TH_BITS-1:0]    sum_sat, prod_sat;

    t_in_item  r_item;
    t_out_item r_out;
    logic      r_out_valid;
    logic      out_free;
    logic      cfg_fire, in_fire;

    logic [TH_BITS-1:0] uv_q, fb_q, cs_q;
    logic               faulted;

    assign out_free = !r_out_valid || o_out.ready;
    assign cfg_fire = i_cfg.valid && ctrl.cfg_ready;
    assign in_fire  = i_in.valid && ctrl.in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cfg_fire) begin
                    n_state = ST_CALC;
                end else if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = n_recalc ? ST_CALC : ST_IDLE;
                end
            end
            ST_CALC: begin
                if (r_step == CALC_GOOD_LO) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                ctrl.cfg_ready = 1'b1;
                ctrl.in_ready  = !i_cfg.valid;
            end
            ST_EXEC: ctrl.exec_fire = out_free;
            ST_CALC: ctrl.calc_en   = 1'b1;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CALC;
            r_step  <= CALC_TARGET;
        end else begin
            r_state <= n_state;
            if (ctrl.calc_en && r_step != CALC_GOOD_LO) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= CALC_TARGET;
            end
        end
    end

    // event decision
    assign uv_q    = to_q8(r_item.uvlo_sample);
    assign fb_q    = to_q8(r_item.vfb_sample);
    assign cs_q    = to_q8(r_item.csense_sample);
    assign faulted = (r_fault != FC_NONE);

    always_comb begin
        n_fault   = r_fault;
        n_mode    = r_mode;
        n_edit    = r_edit;
        n_uv_set  = r_uv_set;
        n_out_set = r_out_set;
        n_cur_set = r_cur_set;
        n_good    = r_good;
        n_sw_on   = r_sw_on;
        n_shdn    = r_shdn;
        n_pwm     = r_pwm;
        n_recalc  = 1'b0;
        case (r_item.kind)
            KIND_SAMPLE: begin
                if (!faulted) begin
                    if (uv_q <= r_uv_th) begin
                        n_fault = FC_UVLO;
                        n_sw_on = 1'b0;
                        n_shdn  = 1'b1;
                        n_pwm   = 1'b0;
                        n_mode  = MODE_OFF;
                        n_edit  = '0;
                    end else if (fb_q >= r_ov_th) begin
                        n_fault = FC_OVP;
                        n_sw_on = 1'b0;
                        n_shdn  = 1'b1;
                        n_pwm   = 1'b1;
                        n_mode  = MODE_OFF;
                        n_edit  = '0;
                    end else if (cs_q >= r_oc_th) begin
                        n_fault = FC_OCP;
                        n_sw_on = 1'b1;
                        n_shdn  = 1'b1;
                        n_pwm   = 1'b1;
                        n_mode  = MODE_OFF;
                        n_edit  = '0;
                    end else if (fb_q >= r_pgu_th) begin
                        n_good = 1'b1;
                    end else if (fb_q <= r_pgl_th) begin
                        n_good = 1'b0;
                    end
                end
            end
            KIND_SHORT: begin
                n_fault = FC_SCP;
                n_sw_on = 1'b0;
                n_shdn  = 1'b1;
                n_pwm   = 1'b0;
                n_mode  = MODE_OFF;
                n_edit  = '0;
            end
            KIND_MODE: begin
                if (!faulted) begin
                    case (r_mode)
                        MODE_OFF: begin
                            n_mode = MODE_UVLO;
                            n_edit = r_uv_set;
                        end
                        MODE_UVLO: begin
                            n_mode = MODE_VOUT;
                            n_edit = r_out_set;
                        end
                        MODE_VOUT: begin
                            n_mode = MODE_CURR;
                            n_edit = r_cur_set;
                        end
                        default: begin
                            n_mode = MODE_OFF;
                            n_edit = '0;
                        end
                    endcase
                end
            end
            KIND_PLUS: begin
                if (!faulted && r_edit != SETTING_MAX) begin
                    n_edit = r_edit + 1'b1;
                end
            end
            KIND_MINUS: begin
                if (!faulted && r_edit != '0) begin
                    n_edit = r_edit - 1'b1;
                end
            end
            KIND_OK: begin
                if (faulted) begin
                    n_fault = FC_NONE;
                    n_sw_on = 1'b1;
                    n_shdn  = 1'b0;
                    n_pwm   = 1'b1;
                end else if (r_mode != MODE_OFF) begin
                    n_recalc = 1'b1;
                    case (r_mode)
                        MODE_UVLO: n_uv_set  = r_edit;
                        MODE_VOUT: n_out_set = r_edit;
                        default:   n_cur_set = r_edit;
                    endcase
                end
            end
            default: n_recalc = 1'b0;
        endcase
    end

    // supervisor state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= FC_NONE;
            r_mode      <= MODE_OFF;
            r_edit      <= '0;
            r_uv_set    <= UV_SET_RST;
            r_out_set   <= OUT_SET_RST;
            r_cur_set   <= CUR_SET_RST;
            r_good      <= 1'b0;
            r_sw_on     <= 1'b1;
            r_shdn      <= 1'b0;
            r_pwm       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ctrl.exec_fire) begin
                r_fault     <= n_fault;
                r_mode      <= n_mode;
                r_edit      <= n_edit;
                r_uv_set    <= n_uv_set;
                r_out_set   <= n_out_set;
                r_cur_set   <= n_cur_set;
                r_good      <= n_good;
                r_sw_on     <= n_sw_on;
                r_shdn      <= n_shdn;
                r_pwm       <= n_pwm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in.data;
        end
        if (ctrl.exec_fire) begin
            r_out.power_switch_on    <= n_sw_on;
            r_out.converter_shutdown <= n_shdn;
            r_out.pwm_running        <= n_pwm;
            r_out.output_ok          <= n_good;
            r_out.warning_code       <= n_fault;
            r_out.menu_mode          <= n_mode;
            r_out.edit_value         <= n_edit;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvlo_gain  <= UVLO_GAIN_RST;
            r_vout_gain  <= VOUT_GAIN_RST;
            r_ovp_margin <= OVP_MARG_RST;
            r_ocp_offset <= OCP_OFFS_RST;
            r_ocp_gain   <= OCP_GAIN_RST;
            r_pg_upper   <= PG_UPPER_RST;
            r_pg_lower   <= PG_LOWER_RST;
        end else if (cfg_fire) begin
            case (i_cfg.data.index)
                REG_UVLO_GAIN: r_uvlo_gain  <= i_cfg.data.value[GAIN_BITS-1:0];
                REG_VOUT_GAIN: r_vout_gain  <= i_cfg.data.value[GAIN_BITS-1:0];
                REG_OVP_MARG:  r_ovp_margin <= i_cfg.data.value[MARGIN_BITS-1:0];
                REG_OCP_OFFS:  r_ocp_offset <= i_cfg.data.value[OFFSET_BITS-1:0];
                REG_OCP_GAIN:  r_ocp_gain   <= i_cfg.data.value[GAIN_BITS-1:0];
                REG_PG_UPPER:  r_pg_upper   <= i_cfg.data.value[GAIN_BITS-1:0];
                REG_PG_LOWER:  r_pg_lower   <= i_cfg.data.value[GAIN_BITS-1:0];
                default:       r_pg_lower   <= r_pg_lower;
            endcase
        end
    end

    // multiplier operand select per recompute step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            CALC_TARGET: begin
                mul_a = MUL_A_BITS'(r_out_set);
                mul_b = r_vout_gain;
            end
            CALC_UNDER: begin
                mul_a = MUL_A_BITS'(r_uv_set);
                mul_b = r_uvlo_gain;
            end
            CALC_OVER: begin
                mul_a = MUL_A_BITS'(r_cur_set);
                mul_b = r_ocp_gain;
            end
            CALC_CURR: begin
                mul_a = r_target;
                mul_b = r_pg_upper;
            end
            CALC_GOOD_HI: begin
                mul_a = r_target;
                mul_b = r_pg_lower;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared saturating adder: margin on target, then offset on current product
    always_comb begin
        if (r_step == CALC_OVER) begin
            add_a = MUL_BITS'(r_target);
            add_b = OFFSET_BITS'(r_ovp_margin);
        end else begin
            add_a = r_prod;
            add_b = r_ocp_offset;
        end
    end

    assign sum      = SUM_BITS'(add_a) + SUM_BITS'(add_b);
    assign sum_sat  = (|sum[SUM_BITS-1:TH_BITS]) ? TH_MAX : sum[TH_BITS-1:0];
    assign prod_sat = (|r_prod[MUL_BITS-1:TH_BITS]) ? TH_MAX : r_prod[TH_BITS-1:0];

    // threshold recompute datapath
    always_ff @(posedge i_clk) begin
        if (ctrl.calc_en) begin
            r_prod <= mul_a * mul_b;
            case (r_step)
                CALC_UNDER: r_target <= prod_sat;
                CALC_OVER: begin
                    r_uv_th <= prod_sat;
                    r_ov_th <= sum_sat;
                end
                CALC_CURR:    r_oc_th  <= sum_sat;
                CALC_GOOD_HI: r_pgu_th <= r_prod[MUL_BITS-1:GAIN_BITS];
                CALC_GOOD_LO: r_pgl_th <= r_prod[MUL_BITS-1:GAIN_BITS];
                default:      r_target <= r_target;
            endcase
        end
    end

    assign i_in.ready  = ctrl.in_ready;
    assign i_cfg.ready = ctrl.cfg_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    // a register write always restarts the recompute from its first step
    a_cfg_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (r_state == ST_CALC) && (r_step == CALC_TARGET))
        else $error("config write did not start threshold recompute");

    // a latched fault keeps the menu closed
    a_fault_menu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != FC_NONE) |-> (r_mode == MODE_OFF) && (r_edit == '0))
        else $error("menu active while a fault is latched");

    // a new result only comes from the decision cycle
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EXEC))
        else $error("result word raised outside decision cycle");

    // no input word is taken while thresholds are being rebuilt
    a_calc_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> !i_in.ready && !i_cfg.ready)
        else $error("handshake open during recompute");

    // the reported state matches the registered supervisor state
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.warning_code == r_fault) && (r_out.menu_mode == r_mode))
        else $error("result word disagrees with supervisor state");
`endif

endmodule

/* bench/dc_dc_protection_supervisor_top_tb.sv */
`timescale 1ns / 1ps

module dc_dc_protection_supervisor_top_tb;
    import dcps_pkg::*;

    // codes the package leaves unnamed
    localparam logic [2:0]              KIND_SPARE_LO = 3'd6;
    localparam logic [2:0]              KIND_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE     = 3'd7;
    localparam int                      ADC_TOP       = (1 << ADC_BITS) - 1;

    typedef enum {PLAN_RESET, PLAN_SCALED, PLAN_ZERO, PLAN_FULL} t_reg_plan;

    // supervisor state tracker and queue of expected status words
    class t_status_tracker;
        logic [CFG_DAT_BITS-1:0] reg_file [7];
        logic [2:0]              fault;
        logic [1:0]              mode;
        logic [SETTING_BITS-1:0] edit_val;
        logic [SETTING_BITS-1:0] uv_set;
        logic [SETTING_BITS-1:0] out_set;
        logic [SETTING_BITS-1:0] cur_set;
        logic [TH_BITS-1:0]      uv_th;
        logic [TH_BITS-1:0]      ov_th;
        logic [TH_BITS-1:0]      oc_th;
        logic [TH_BITS-1:0]      good_hi_th;
        logic [TH_BITS-1:0]      good_lo_th;
        logic                    good;
        logic                    sw_on;
        logic                    shut;
        logic                    pwm;
        t_out_item               pending_status[$];
        int                      errors;

        function new();
            for (int k = REG_UVLO_GAIN; k <= REG_PG_LOWER; k++) begin
                reg_file[k] = reset_value(CFG_IDX_BITS'(k));
            end
            fault    = FC_NONE;
            mode     = MODE_OFF;
            edit_val = '0;
            uv_set   = UV_SET_RST;
            out_set  = OUT_SET_RST;
            cur_set  = CUR_SET_RST;
            good     = 1'b0;
            sw_on    = 1'b1;
            shut     = 1'b0;
            pwm      = 1'b1;
            errors   = 0;
            refresh_thresholds();
        endfunction

        static function logic [CFG_DAT_BITS-1:0] reset_value(logic [CFG_IDX_BITS-1:0] idx);
            case (idx)
                REG_UVLO_GAIN: return CFG_DAT_BITS'(UVLO_GAIN_RST);
                REG_VOUT_GAIN: return CFG_DAT_BITS'(VOUT_GAIN_RST);
                REG_OVP_MARG:  return CFG_DAT_BITS'(OVP_MARG_RST);
                REG_OCP_OFFS:  return CFG_DAT_BITS'(OCP_OFFS_RST);
                REG_OCP_GAIN:  return CFG_DAT_BITS'(OCP_GAIN_RST);
                REG_PG_UPPER:  return CFG_DAT_BITS'(PG_UPPER_RST);
                REG_PG_LOWER:  return CFG_DAT_BITS'(PG_LOWER_RST);
                default:       return '0;
            endcase
        endfunction

        function logic [TH_BITS-1:0] clamp24(logic [63:0] v);
            return (v > 64'(TH_MAX)) ? TH_MAX : v[TH_BITS-1:0];
        endfunction

        // thresholds in q.8 codes from settings and gains
        function void refresh_thresholds();
            logic [TH_BITS-1:0] target;
            target     = clamp24(64'(out_set) * 64'(reg_file[REG_VOUT_GAIN]));
            uv_th      = clamp24(64'(uv_set) * 64'(reg_file[REG_UVLO_GAIN]));
            ov_th      = clamp24(64'(target) + 64'(reg_file[REG_OVP_MARG]));
            oc_th      = clamp24(64'(reg_file[REG_OCP_OFFS])
                                 + 64'(cur_set) * 64'(reg_file[REG_OCP_GAIN]));
            good_hi_th = TH_BITS'((64'(target) * 64'(reg_file[REG_PG_UPPER])) >> GAIN_BITS);
            good_lo_th = TH_BITS'((64'(target) * 64'(reg_file[REG_PG_LOWER])) >> GAIN_BITS);
        endfunction

        // registers keep only their own width, unused index ignored
        function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DAT_BITS-1:0] val);
            if (idx > REG_PG_LOWER) return;
            case (idx)
                REG_OVP_MARG: reg_file[idx] = CFG_DAT_BITS'(val[MARGIN_BITS-1:0]);
                REG_OCP_OFFS: reg_file[idx] = val;
                default:      reg_file[idx] = CFG_DAT_BITS'(val[GAIN_BITS-1:0]);
            endcase
            refresh_thresholds();
        endfunction

        function void latch_fault(logic [2:0] code, logic sw, logic sd, logic pw);
            fault    = code;
            sw_on    = sw;
            shut     = sd;
            pwm      = pw;
            mode     = MODE_OFF;
            edit_val = '0;
        endfunction

        // apply one accepted event and queue the status it should produce
        function void take_event(t_in_item ev);
            logic [TH_BITS-1:0] uv;
            logic [TH_BITS-1:0] fb;
            logic [TH_BITS-1:0] cs;
            logic               faulted;
            t_out_item          r;
            uv      = TH_BITS'(ev.uvlo_sample) << FRAC_BITS;
            fb      = TH_BITS'(ev.vfb_sample) << FRAC_BITS;
            cs      = TH_BITS'(ev.csense_sample) << FRAC_BITS;
            faulted = (fault != FC_NONE);
            case (ev.kind)
                KIND_SAMPLE: begin
                    if (!faulted) begin
                        if (uv <= uv_th) latch_fault(FC_UVLO, 1'b0, 1'b1, 1'b0);
                        else if (fb >= ov_th) latch_fault(FC_OVP, 1'b0, 1'b1, 1'b1);
                        else if (cs >= oc_th) latch_fault(FC_OCP, 1'b1, 1'b1, 1'b1);
                        else if (fb >= good_hi_th) good = 1'b1;
                        else if (fb <= good_lo_th) good = 1'b0;
                    end
                end
                KIND_SHORT: latch_fault(FC_SCP, 1'b0, 1'b1, 1'b0);
                KIND_MODE: begin
                    if (!faulted) begin
                        case (mode)
                            MODE_OFF: begin
                                mode     = MODE_UVLO;
                                edit_val = uv_set;
                            end
                            MODE_UVLO: begin
                                mode     = MODE_VOUT;
                                edit_val = out_set;
                            end
                            MODE_VOUT: begin
                                mode     = MODE_CURR;
                                edit_val = cur_set;
                            end
                            default: begin
                                mode     = MODE_OFF;
                                edit_val = '0;
                            end
                        endcase
                    end
                end
                KIND_PLUS: if (!faulted && edit_val != SETTING_MAX) edit_val++;
                KIND_MINUS: if (!faulted && edit_val != '0) edit_val--;
                KIND_OK: begin
                    if (faulted) begin
                        fault = FC_NONE;
                        sw_on = 1'b1;
                        shut  = 1'b0;
                        pwm   = 1'b1;
                    end else if (mode != MODE_OFF) begin
                        case (mode)
                            MODE_UVLO: uv_set  = edit_val;
                            MODE_VOUT: out_set = edit_val;
                            default:   cur_set = edit_val;
                        endcase
                        refresh_thresholds();
                    end
                end
                default: ;
            endcase
            r.power_switch_on    = sw_on;
            r.converter_shutdown = shut;
            r.pwm_running        = pwm;
            r.output_ok          = good;
            r.warning_code       = fault;
            r.menu_mode          = mode;
            r.edit_value         = edit_val;
            pending_status.push_back(r);
        endfunction

        function string describe(t_out_item s);
            return $sformatf("sw=%0b sd=%0b pwm=%0b pg=%0b warn=%0d mode=%0d edit=%0d",
                             s.power_switch_on, s.converter_shutdown, s.pwm_running,
                             s.output_ok, s.warning_code, s.menu_mode, s.edit_value);
        endfunction

        // compare one returned status word with the oldest expectation
        function void check_status(t_out_item got);
            t_out_item want;
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: status word with none expected: %s", $time, describe(got));
                return;
            end
            want = pending_status.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: status mismatch, expected %s, actual %s",
                         $time, describe(want), describe(got));
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    dcps_item_if     in_if();
    dcps_result_if   out_if();
    dcps_cfg_if      cfg_if();
    t_status_tracker tracker = new();
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              drain_cycles;

    dc_dc_protection_supervisor_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // status words: check on accept, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            tracker.check_status(out_if.data);
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic t_in_item make_sample(input int uv, input int fb, input int cs);
        t_in_item r;
        r.kind          = KIND_SAMPLE;
        r.uvlo_sample   = ADC_BITS'(uv);
        r.vfb_sample    = ADC_BITS'(fb);
        r.csense_sample = ADC_BITS'(cs);
        return r;
    endfunction

    // button or pin word, sample fields filled with noise
    function automatic t_in_item make_press(input logic [2:0] kind);
        return '{kind: kind,
                 uvlo_sample: ADC_BITS'($urandom_range(ADC_TOP)),
                 vfb_sample: ADC_BITS'($urandom_range(ADC_TOP)),
                 csense_sample: ADC_BITS'($urandom_range(ADC_TOP))};
    endfunction

    // adc code within two steps of a q.8 threshold
    function automatic logic [ADC_BITS-1:0] near_code(input logic [TH_BITS-1:0] th);
        int c;
        c = int'(th >> FRAC_BITS) + int'($urandom_range(4)) - 2;
        if (c < 0) c = 0;
        if (c > ADC_TOP) c = ADC_TOP;
        return ADC_BITS'(c);
    endfunction

    // random event, samples steered toward the live thresholds
    function automatic t_in_item random_event();
        t_in_item ev;
        int       pick;
        ev   = make_press(KIND_SAMPLE);
        pick = $urandom_range(99);
        if (tracker.fault != FC_NONE && pick < 25) begin
            ev.kind = KIND_OK;
        end else if (pick < 55) begin
            case ($urandom_range(3))
                0:       ev.uvlo_sample = near_code(tracker.uv_th);
                1, 2:    ev.uvlo_sample = ADC_BITS'(ADC_TOP);
                default: ;
            endcase
            case ($urandom_range(3))
                0:       ev.vfb_sample = near_code(tracker.ov_th);
                1:       ev.vfb_sample = near_code(tracker.good_hi_th);
                2:       ev.vfb_sample = near_code(tracker.good_lo_th);
                default: ;
            endcase
            if ($urandom_range(1)) ev.csense_sample = near_code(tracker.oc_th);
        end else if (pick < 60) begin
            ev.kind = KIND_SHORT;
        end else if (pick < 72) begin
            ev.kind = KIND_MODE;
        end else if (pick < 82) begin
            ev.kind = KIND_PLUS;
        end else if (pick < 90) begin
            ev.kind = KIND_MINUS;
        end else if (pick < 97) begin
            ev.kind = KIND_OK;
        end else begin
            ev.kind = $urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end
        return ev;
    endfunction

    // drive one input word, hold it until taken
    task automatic send_event(input t_in_item ev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= ev;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.take_event(ev);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            // hold off once until every pending word is back
            if (i == count / 2) begin
                in_if.valid <= 1'b0;
                while (tracker.pending_status.size() != 0) @(posedge i_clk);
            end
            send_event(random_event());
        end
    endtask

    // stop sending and let the block go idle
    task automatic settle();
        in_if.valid <= 1'b0;
        while (tracker.pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write every register index, spare one included
    task automatic program_registers(input t_reg_plan plan);
        logic [CFG_DAT_BITS-1:0] v;
        for (int k = REG_UVLO_GAIN; k <= REG_SPARE; k++) begin
            case (plan)
                PLAN_RESET: v = t_status_tracker::reset_value(CFG_IDX_BITS'(k));
                PLAN_ZERO:  v = '0;
                PLAN_FULL:  v = '1;
                default: begin
                    if (k == REG_SPARE)
                        v = CFG_DAT_BITS'($urandom());
                    else
                        v = CFG_DAT_BITS'((64'(t_status_tracker::reset_value(CFG_IDX_BITS'(k)))
                                           * $urandom_range(160, 40)) / 100);
                end
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= '{index: CFG_IDX_BITS'(k), value: v};
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            tracker.write_register(CFG_IDX_BITS'(k), v);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // drive one setting to its floor or ceiling and apply it
    task automatic sweep_setting(input logic [1:0] target, input logic [2:0] dir);
        int presses;
        if (tracker.fault != FC_NONE) send_event(make_press(KIND_OK));
        while (tracker.mode != target) send_event(make_press(KIND_MODE));
        presses = (dir == KIND_PLUS) ? int'(SETTING_MAX) - int'(tracker.edit_val) + 3
                                     : int'(tracker.edit_val) + 3;
        repeat (presses) send_event(make_press(dir));
        send_event(make_press(KIND_OK));
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        send_event(make_sample(ADC_TOP, 1000, 0));
        send_event(make_sample(ADC_TOP, 900, 2481));
        send_event(make_sample(ADC_TOP, 870, 0));
        send_event(make_sample(1726, 973, 0));
        send_event(make_sample(1725, 0, 0));
        send_event(make_sample(0, ADC_TOP, ADC_TOP));
        send_event(make_press(KIND_MODE));
        send_event(make_press(KIND_PLUS));
        send_event(make_press(KIND_MINUS));
        send_event(make_press(KIND_SHORT));
        send_event(make_press(KIND_OK));
        send_event(make_sample(ADC_TOP, 1117, ADC_TOP));
        send_event(make_press(KIND_OK));
        send_event(make_sample(ADC_TOP, 1116, 2482));
        send_event(make_press(KIND_OK));
        send_event(make_press(KIND_MINUS));
        send_event(make_press(KIND_PLUS));
        send_event(make_press(KIND_OK));
        send_event(make_press(KIND_MODE));
        send_event(make_press(KIND_PLUS));
        send_event(make_press(KIND_OK));
        send_event(make_press(KIND_MODE));
        send_event(make_press(KIND_MODE));
        send_event(make_press(KIND_MODE));
        send_event(make_press(KIND_SPARE_LO));
        send_event(make_press(KIND_SPARE_HI));
        run_random(120);

        // scaled gains, sparse sender
        settle();
        program_registers(PLAN_SCALED);
        send_idle_pct = 82;
        run_random(100);

        // all registers zero, slow receiver
        settle();
        program_registers(PLAN_ZERO);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_random(30);

        // all register bits set, light idling on both sides
        settle();
        program_registers(PLAN_FULL);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random(30);

        settle();
        program_registers(PLAN_SCALED);
        run_random(80);

        // output setting driven to its floor at reset gains
        settle();
        program_registers(PLAN_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sweep_setting(MODE_VOUT, KIND_MINUS);
        run_random(25);

        // drain and report
        in_if.valid <= 1'b0;
        drain_cycles = 0;
        while (tracker.pending_status.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (tracker.pending_status.size() != 0) begin
            tracker.errors += tracker.pending_status.size();
            $display("%0t: %0d expected status words never came",
                     $time, tracker.pending_status.size());
        end
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/dcps_pkg.sv
design/dcps_item_if.sv
design/dcps_result_if.sv
design/dcps_cfg_if.sv
design/dc_dc_protection_supervisor_top.sv
bench/dc_dc_protection_supervisor_top_tb.sv
